// ----- hw/rtl/trs_pkg.sv -----
package trs_pkg;

    // Song geometry
    localparam int ROWS_PER_PATTERN = 64;
    localparam int MAX_POSITIONS    = 128;

    // Field widths
    localparam int OP_W  = 3;
    localparam int TGT_W = 8;
    localparam int LEN_W = 8;
    localparam int POS_W = 7;
    localparam int ROW_W = 6;

    localparam logic [LEN_W-1:0] SONG_LEN_RESET = LEN_W'(1);

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_RESTART = 3'd0,
        OP_ADVANCE = 3'd1,
        OP_JUMP    = 3'd2,
        OP_SET_ROW = 3'd3,
        OP_SET_POS = 3'd4
    } op_t;

endpackage

// ----- hw/rtl/tracker_row_sequencer_core.sv -----
// Tracker row sequencer: keeps the playback location of a song (position,
// row within a 64-row pattern, a queued jump and an end-of-song flag). Each
// accepted item carries one operation (restart, advance row, queue jump,
// set row, set position) and yields exactly one result that reports the
// location after that operation. An item can be accepted every clock cycle
// while item_stall is low. Each item passes through one input register and
// then the location registers, which also serve as the result register. The
// rate is set by the single update of the location registers per cycle. A
// stalled result holds the location registers, and once the input register
// is also full the input channel stalls. song_length is written through the
// cfg port; values above 128 act as 128, and a length of zero ignores every
// jump and position set.
module tracker_row_sequencer_core
    import trs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    // Input item channel
    input  logic                    item_valid,
    output logic                    item_stall,
    input  logic [OP_W-1:0]         operation,
    input  logic [TGT_W-1:0]        target_position,
    input  logic [TGT_W-1:0]        target_row,

    // Result channel
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic [POS_W-1:0]        position,
    output logic [ROW_W-1:0]        row,
    output logic                    end_of_song,
    output logic                    jump_pending,

    // Configuration write channel
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [LEN_W-1:0]        cfg_data
);

    // Input stage
    logic                   in_valid_reg, in_valid_next;
    logic [OP_W-1:0]        in_op_reg;
    logic [TGT_W-1:0]       in_tpos_reg;
    logic [TGT_W-1:0]       in_trow_reg;

    // Location state, doubling as the result register
    logic                   res_valid_reg, res_valid_next;
    logic [POS_W-1:0]       cur_pos_reg, cur_pos_next;
    logic [ROW_W-1:0]       cur_row_reg, cur_row_next;
    logic [POS_W-1:0]       jump_pos_reg, jump_pos_next;
    logic [ROW_W-1:0]       jump_row_reg, jump_row_next;
    logic                   jump_flag_reg, jump_flag_next;
    logic                   ended_reg, ended_next;
    logic [LEN_W-1:0]       song_len_reg;

    logic                   item_xfer;
    logic                   step_fire;
    logic [LEN_W-1:0]       eff_len;
    logic [LEN_W-1:0]       pos_plus1;
    logic [ROW_W:0]         row_plus1;
    logic                   tpos_ok;
    logic                   trow_ok;
    op_t                    op;

    // Handshake control
    assign step_fire    = in_valid_reg && (!res_valid_reg || !result_stall);
    assign item_stall   = in_valid_reg && !step_fire;
    assign item_xfer    = item_valid && !item_stall;
    assign result_valid = res_valid_reg;
    assign cfg_ready    = 1'b1;

    always_comb
    begin
        if (item_xfer)
            in_valid_next = 1'b1;
        else if (step_fire)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (step_fire)
            res_valid_next = 1'b1;
        else if (!result_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    // Range checks against the saturated song length
    assign eff_len   = (song_len_reg > LEN_W'(MAX_POSITIONS)) ? LEN_W'(MAX_POSITIONS)
                                                              : song_len_reg;
    assign pos_plus1 = {1'b0, cur_pos_reg} + LEN_W'(1);
    assign row_plus1 = {1'b0, cur_row_reg} + (ROW_W+1)'(1);
    assign tpos_ok   = in_tpos_reg < eff_len;
    assign trow_ok   = in_trow_reg < TGT_W'(ROWS_PER_PATTERN);
    assign op        = op_t'(in_op_reg);

    // Next location for the operation in the input stage
    always_comb
    begin
        cur_pos_next   = cur_pos_reg;
        cur_row_next   = cur_row_reg;
        jump_pos_next  = jump_pos_reg;
        jump_row_next  = jump_row_reg;
        jump_flag_next = jump_flag_reg;
        ended_next     = ended_reg;

        case (op)
            OP_RESTART:
            begin
                cur_pos_next   = '0;
                cur_row_next   = '0;
                jump_flag_next = 1'b0;
                ended_next     = 1'b0;
            end
            OP_ADVANCE:
            begin
                if (!ended_reg)
                begin
                    if (jump_flag_reg)
                    begin
                        cur_pos_next   = jump_pos_reg;
                        cur_row_next   = jump_row_reg;
                        jump_flag_next = 1'b0;
                    end
                    else if (row_plus1 >= (ROW_W+1)'(ROWS_PER_PATTERN))
                    begin
                        // Wrap the pattern; end the song past the last position
                        cur_row_next = '0;
                        if (pos_plus1 >= eff_len)
                            ended_next = 1'b1;
                        else
                            cur_pos_next = pos_plus1[POS_W-1:0];
                    end
                    else
                    begin
                        cur_row_next = row_plus1[ROW_W-1:0];
                    end
                end
            end
            OP_JUMP:
            begin
                if (tpos_ok && trow_ok)
                begin
                    jump_pos_next  = in_tpos_reg[POS_W-1:0];
                    jump_row_next  = in_trow_reg[ROW_W-1:0];
                    jump_flag_next = 1'b1;
                end
            end
            OP_SET_ROW:
            begin
                if (trow_ok)
                    cur_row_next = in_trow_reg[ROW_W-1:0];
            end
            OP_SET_POS:
            begin
                if (tpos_ok)
                begin
                    cur_pos_next = in_tpos_reg[POS_W-1:0];
                    cur_row_next = '0;
                end
            end
            default:
            begin
                // Unknown codes leave the location as it is
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            song_len_reg  <= SONG_LEN_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
                song_len_reg <= cfg_data;
        end
    end

    // Capture the item on transfer
    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            in_op_reg   <= operation;
            in_tpos_reg <= target_position;
            in_trow_reg <= target_row;
        end
    end

    // Location state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_pos_reg   <= '0;
            cur_row_reg   <= '0;
            jump_pos_reg  <= '0;
            jump_row_reg  <= '0;
            jump_flag_reg <= 1'b0;
            ended_reg     <= 1'b0;
        end
        else if (step_fire)
        begin
            cur_pos_reg   <= cur_pos_next;
            cur_row_reg   <= cur_row_next;
            jump_pos_reg  <= jump_pos_next;
            jump_row_reg  <= jump_row_next;
            jump_flag_reg <= jump_flag_next;
            ended_reg     <= ended_next;
        end
    end

    assign position     = cur_pos_reg;
    assign row          = cur_row_reg;
    assign end_of_song  = ended_reg;
    assign jump_pending = jump_flag_reg;

    // End of song is only ever raised by an advance
    a_end_by_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ended_reg) |-> $past(step_fire && in_op_reg == OP_ADVANCE))
        else $error("end of song set by an operation other than advance");

    // A queued jump only appears through a queue jump operation
    a_jump_by_queue: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(jump_flag_reg) |-> $past(step_fire && in_op_reg == OP_JUMP))
        else $error("jump flag set by an operation other than queue jump");

    // Restart returns to the top of the song
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && in_op_reg == OP_RESTART) |=>
            (cur_pos_reg == '0 && cur_row_reg == '0 && !ended_reg && !jump_flag_reg))
        else $error("restart did not clear the location");

    // Location changes only when a step produces a result
    a_state_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable({cur_pos_reg, cur_row_reg, ended_reg, jump_flag_reg}) |-> res_valid_reg)
        else $error("location changed without a result");

endmodule
